FILE: rtl/crr_pkg.sv
// Shared types, register codes and the binomial helper for the
// combination rank/unrank core. No dependencies.
`default_nettype none

package crr_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W  = 6;

  // Configuration register indexes
  localparam logic CFG_SET_SIZE     = 1'b0;
  localparam logic CFG_CHOSEN_COUNT = 1'b1;

  localparam logic [CNT_W-1:0] SET_SIZE_RST     = 6'd32;
  localparam logic [CNT_W-1:0] CHOSEN_COUNT_RST = 6'd16;

  // Input action codes
  localparam logic ACT_RANK   = 1'b0;
  localparam logic ACT_UNRANK = 1'b1;

  // Per-transaction payload carried down the chain.
  // data: shifted subset vector (rank) or remaining index (unrank).
  // acc : running rank (rank) or collected subset bits (unrank).
  typedef struct packed {
    logic              action;
    logic [CNT_W-1:0]  kl;
    logic [DATA_W-1:0] data;
    logic [DATA_W-1:0] acc;
  } stage_t;

  // Exact C(a,b) via Pascal's rule; only ever called with constant args.
  function automatic logic [DATA_W-1:0] binom(input int a, input int b);
    logic [DATA_W-1:0] row [33];
    logic [DATA_W-1:0] res;
    for (int i = 0; i < 33; i++) begin
      row[i] = '0;
    end
    row[0] = 32'd1;
    for (int i = 1; i <= a; i++) begin
      for (int j = i; j >= 1; j--) begin
        row[j] = row[j] + row[j-1];
      end
    end
    if (b < 0 || a < 0 || a > 32 || b > a) begin
      res = '0;
    end else begin
      res = row[b];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/crr_cell.sv
// One position cell of the rank/unrank chain: handles the step with POS
// positions remaining. Depends on crr_pkg.
`default_nettype none

module crr_cell #(
  parameter int MAX_SET_SIZE = 32,
  parameter int POS          = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [crr_pkg::CNT_W-1:0] n_i,
  input  logic                      valid_i,
  input  crr_pkg::stage_t           stage_i,
  output logic                      valid_o,
  output crr_pkg::stage_t           stage_o
);

  localparam int IDXW      = (MAX_SET_SIZE > 1) ? $clog2(MAX_SET_SIZE) : 1;
  localparam int COL_DEPTH = 2 ** IDXW;
  localparam int BITPOS    = MAX_SET_SIZE - POS;

  // ROM column C(POS-1, b)
  logic [crr_pkg::DATA_W-1:0] col [COL_DEPTH];

  for (genvar b = 0; b < COL_DEPTH; b++) begin : g_col
    assign col[b] = crr_pkg::binom(POS - 1, b);
  end

  logic [crr_pkg::CNT_W-1:0]  kl_m1;
  logic [crr_pkg::DATA_W-1:0] coef;
  logic                       active;
  logic                       valid_q;
  crr_pkg::stage_t            stage_d, stage_q;

  always_comb begin
    kl_m1  = stage_i.kl - 6'd1;
    coef   = (kl_m1 < 6'(COL_DEPTH)) ? col[kl_m1[IDXW-1:0]] : '0;
    active = (6'(POS) <= n_i) && (stage_i.kl != '0);

    stage_d = stage_i;
    if (active) begin
      if (stage_i.action == crr_pkg::ACT_RANK) begin
        if (stage_i.data[BITPOS]) begin
          stage_d.kl = kl_m1;
        end else begin
          stage_d.acc = stage_i.acc + coef;
        end
      end else begin
        if (stage_i.data < coef) begin
          stage_d.acc[BITPOS] = 1'b1;
          stage_d.kl          = kl_m1;
        end else begin
          stage_d.data = stage_i.data - coef;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

`default_nettype wire

FILE: rtl/combination_rank_unrank_core.sv
// Top level of the combination rank/unrank core: config registers, input
// alignment, the chain of crr_cell instances and the output register.
// Depends on crr_pkg and crr_cell.
//
// Converts between a k-of-n subset bit vector (bit 0 = first position, a set
// bit sorts first) and its lexicographic index. action 0 ranks subset_bits_i;
// action 1 unranks index_i and raises out_of_range_o when the index is at or
// above C(n,k), returning a zero subset. It accepts one transaction per clock
// while the output is not stalled; results pass through the chain of
// MAX_SET_SIZE registered cells (one per position) and then the output register.
// Backpressure on the output freezes the whole chain, so in_ready_o is high
// whenever the output register is empty or being drained this cycle.
// Configuration (set_size, chosen_count) is a plain write port and must only
// be changed while no transaction is in flight; set_size saturates at
// MAX_SET_SIZE.
`default_nettype none

module combination_rank_unrank_core #(
  parameter int MAX_SET_SIZE = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // config write port
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [crr_pkg::CNT_W-1:0]  cfg_data_i,
  // input channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       action_i,
  input  logic [crr_pkg::DATA_W-1:0] subset_bits_i,
  input  logic [crr_pkg::DATA_W-1:0] index_i,
  // output channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [crr_pkg::DATA_W-1:0] rank_o,
  output logic [crr_pkg::DATA_W-1:0] subset_out_o,
  output logic                       out_of_range_o
);

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  logic [crr_pkg::CNT_W-1:0] set_size_q, chosen_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_size_q     <= crr_pkg::SET_SIZE_RST;
      chosen_count_q <= crr_pkg::CHOSEN_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        crr_pkg::CFG_SET_SIZE:     set_size_q     <= cfg_data_i;
        crr_pkg::CFG_CHOSEN_COUNT: chosen_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective n, saturated at the chain length. Cells work in "positions
  // remaining" order, so position p lives at vector bit MAX_SET_SIZE-n+p.
  logic [crr_pkg::CNT_W-1:0] n_eff;
  logic [crr_pkg::CNT_W-1:0] align_sh;

  assign n_eff    = (set_size_q > 6'(MAX_SET_SIZE)) ? 6'(MAX_SET_SIZE) : set_size_q;
  assign align_sh = 6'(MAX_SET_SIZE) - n_eff;

  // ------------------------------------------------------------------
  // Pipeline control: the whole chain advances when the output slot frees
  // ------------------------------------------------------------------
  logic en;
  logic out_valid_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // ------------------------------------------------------------------
  // Chain of position cells
  // ------------------------------------------------------------------
  logic            chain_valid [MAX_SET_SIZE+1];
  crr_pkg::stage_t chain_stage [MAX_SET_SIZE+1];
  crr_pkg::stage_t stage_in;

  always_comb begin
    stage_in.action = action_i;
    stage_in.kl     = chosen_count_q;
    stage_in.acc    = '0;
    // rank: align the vector so bits past n drop off the top
    stage_in.data   = (action_i == crr_pkg::ACT_RANK) ?
                      (subset_bits_i << align_sh) : index_i;
  end

  assign chain_valid[0] = in_valid_i;
  assign chain_stage[0] = stage_in;

  for (genvar i = 0; i < MAX_SET_SIZE; i++) begin : g_cell
    crr_cell #(
      .MAX_SET_SIZE (MAX_SET_SIZE),
      .POS          (MAX_SET_SIZE - i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .n_i     (n_eff),
      .valid_i (chain_valid[i]),
      .stage_i (chain_stage[i]),
      .valid_o (chain_valid[i+1]),
      .stage_o (chain_stage[i+1])
    );
  end

  // ------------------------------------------------------------------
  // Output register
  // ------------------------------------------------------------------
  crr_pkg::stage_t            last;
  logic                       oor_d;
  logic [crr_pkg::DATA_W-1:0] rank_d, subset_d;
  logic [crr_pkg::DATA_W-1:0] rank_q, subset_q;
  logic                       oor_q;

  // Unrank is in range exactly when the walk used up every chosen element
  // and left nothing of the index; otherwise k never decremented.
  always_comb begin
    last     = chain_stage[MAX_SET_SIZE];
    oor_d    = 1'b0;
    rank_d   = '0;
    subset_d = '0;
    if (last.action == crr_pkg::ACT_RANK) begin
      rank_d = last.acc;
    end else begin
      oor_d = (last.kl != '0) || (last.data != '0);
      if (!oor_d) begin
        subset_d = last.acc >> align_sh;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= chain_valid[MAX_SET_SIZE];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rank_q   <= rank_d;
      subset_q <= subset_d;
      oor_q    <= oor_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign rank_o         = rank_q;
  assign subset_out_o   = subset_q;
  assign out_of_range_o = oor_q;

endmodule

`default_nettype wire

FILE: rtl/crr_checker.sv
// Port-level checker for combination_rank_unrank_core, bound to the top.
// Depends on crr_pkg for field widths.
`default_nettype none

module crr_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [crr_pkg::DATA_W-1:0] rank_o,
  input logic [crr_pkg::DATA_W-1:0] subset_out_o,
  input logic                       out_of_range_o
);

  // a stalled result transaction holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rank_o) &&
    $stable(subset_out_o) && $stable(out_of_range_o))
    else $error("output changed while stalled");

  // the chain only stops when a finished result is blocked
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output slot");

  // an out-of-range unrank carries no subset and no rank
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |-> subset_out_o == '0 && rank_o == '0)
    else $error("out-of-range result is not zero");

  // a result is either a rank or a subset, never both
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && subset_out_o != '0 |-> rank_o == '0 && !out_of_range_o)
    else $error("result mixes rank and subset");

endmodule

bind combination_rank_unrank_core crr_checker u_crr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .rank_o         (rank_o),
  .subset_out_o   (subset_out_o),
  .out_of_range_o (out_of_range_o)
);

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for combination_rank_unrank_core: directed table, then random
// transactions over many register settings, checked against an in-bench predictor.
// Depends on crr_pkg and the core RTL.

module tb;

  localparam int DATA_W = crr_pkg::DATA_W;
  localparam int CNT_W  = crr_pkg::CNT_W;

  localparam logic ACT_RANK         = crr_pkg::ACT_RANK;
  localparam logic ACT_UNRANK       = crr_pkg::ACT_UNRANK;
  localparam logic CFG_SET_SIZE     = crr_pkg::CFG_SET_SIZE;
  localparam logic CFG_CHOSEN_COUNT = crr_pkg::CFG_CHOSEN_COUNT;

  localparam int MAX_N     = 32;
  localparam int LATENCY   = MAX_N + 1;  // chain of cells plus output register
  localparam int RND_ITEMS = 1100;
  localparam int WAIT_MAX  = 18;

  // One result transaction
  typedef struct packed {
    logic [DATA_W-1:0] rank;
    logic [DATA_W-1:0] subset;
    logic              oor;
  } result_t;

  // Directed row: register setting, input transaction, optional typed-in result
  typedef struct packed {
    logic [CNT_W-1:0]  n;
    logic [CNT_W-1:0]  k;
    logic              act;
    logic [DATA_W-1:0] bits;
    logic [DATA_W-1:0] idx;
    logic              typed;
    logic [DATA_W-1:0] rank;
    logic [DATA_W-1:0] subset;
    logic              oor;
  } dir_row_t;

  localparam int DIR_ROWS = 25;

  dir_row_t dir_tab [DIR_ROWS] = '{
    // reset setting 32/16: first and last subsets, both directions
    '{6'd32, 6'd16, ACT_RANK,   32'h0000FFFF, 32'h0, 1'b1, 32'd0,         32'h0,        1'b0},
    '{6'd32, 6'd16, ACT_RANK,   32'hFFFF0000, 32'h0, 1'b1, 32'd601080389, 32'h0,        1'b0},
    '{6'd32, 6'd16, ACT_UNRANK, 32'h0, 32'd0,         1'b1, 32'd0, 32'h0000FFFF,        1'b0},
    '{6'd32, 6'd16, ACT_UNRANK, 32'h0, 32'd601080389, 1'b1, 32'd0, 32'hFFFF0000,        1'b0},
    // index C(32,16) itself, the first out of range, and the largest index
    '{6'd32, 6'd16, ACT_UNRANK, 32'h0, 32'd601080390, 1'b1, 32'd0, 32'h0,               1'b1},
    '{6'd32, 6'd16, ACT_UNRANK, 32'h0, 32'hFFFFFFFF,  1'b1, 32'd0, 32'h0,               1'b1},
    // wrong popcount: all ones, all zeros
    '{6'd32, 6'd16, ACT_RANK,   32'hFFFFFFFF, 32'h0, 1'b1, 32'd0,         32'h0,        1'b0},
    '{6'd32, 6'd16, ACT_RANK,   32'h00000000, 32'h0, 1'b0, 32'd0,         32'h0,        1'b0},
    // empty set: C(0,0) = 1
    '{6'd0,  6'd0,  ACT_RANK,   32'hFFFFFFFF, 32'h0, 1'b1, 32'd0,         32'h0,        1'b0},
    '{6'd0,  6'd0,  ACT_UNRANK, 32'h0, 32'd0,         1'b1, 32'd0, 32'h0,               1'b0},
    '{6'd0,  6'd0,  ACT_UNRANK, 32'h0, 32'd1,         1'b1, 32'd0, 32'h0,               1'b1},
    // k = 0 over the full width
    '{6'd32, 6'd0,  ACT_UNRANK, 32'h0, 32'd0,         1'b1, 32'd0, 32'h0,               1'b0},
    '{6'd32, 6'd0,  ACT_UNRANK, 32'h0, 32'hFFFFFFFF,  1'b1, 32'd0, 32'h0,               1'b1},
    // k = n = 32
    '{6'd32, 6'd32, ACT_UNRANK, 32'h0, 32'd0,         1'b1, 32'd0, 32'hFFFFFFFF,        1'b0},
    '{6'd32, 6'd32, ACT_UNRANK, 32'h0, 32'd1,         1'b1, 32'd0, 32'h0,               1'b1},
    '{6'd32, 6'd32, ACT_RANK,   32'h00000000, 32'h0, 1'b0, 32'd0,         32'h0,        1'b0},
    // set size 63 saturates to 32
    '{6'd63, 6'd5,  ACT_RANK,   32'h0000001F, 32'h0, 1'b1, 32'd0,         32'h0,        1'b0},
    '{6'd63, 6'd5,  ACT_UNRANK, 32'h0, 32'd201375,    1'b1, 32'd0, 32'hF8000000,        1'b0},
    '{6'd63, 6'd5,  ACT_UNRANK, 32'h0, 32'd201376,    1'b1, 32'd0, 32'h0,               1'b1},
    // k above n: nothing is in range
    '{6'd10, 6'd12, ACT_UNRANK, 32'h0, 32'd0,         1'b1, 32'd0, 32'h0,               1'b1},
    '{6'd10, 6'd12, ACT_RANK,   32'h000003FF, 32'h0, 1'b0, 32'd0,         32'h0,        1'b0},
    // single position
    '{6'd1,  6'd1,  ACT_UNRANK, 32'h0, 32'd0,         1'b1, 32'd0, 32'h00000001,        1'b0},
    '{6'd1,  6'd1,  ACT_RANK,   32'h00000000, 32'h0, 1'b0, 32'd0,         32'h0,        1'b0},
    // both registers at their top code
    '{6'd63, 6'd63, ACT_UNRANK, 32'h0, 32'd0,         1'b1, 32'd0, 32'h0,               1'b1},
    // bits beyond n are don't-care for rank
    '{6'd5,  6'd2,  ACT_RANK,   32'hFFFFFFE3, 32'h0, 1'b1, 32'd0,         32'h0,        1'b0}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic              cfg_index = 1'b0;
  logic [CNT_W-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              action = 1'b0;
  logic [DATA_W-1:0] subset_bits = '0;
  logic [DATA_W-1:0] index = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DATA_W-1:0] rank;
  logic [DATA_W-1:0] subset_out;
  logic              out_of_range;

  // Predictor copy of the two registers
  logic [CNT_W-1:0] cur_n = crr_pkg::SET_SIZE_RST;
  logic [CNT_W-1:0] cur_k = crr_pkg::CHOSEN_COUNT_RST;

  result_t         pending_results[$];
  longint unsigned pascal [0:MAX_N][0:MAX_N];
  bit              failed = 1'b0;
  int              rnd_items = 0;

  // Per-side idle pattern: 0 = input channel, 1 = output channel
  int run_left [2] = '{0, 0};
  bit run_calm [2];

  combination_rank_unrank_core #(
    .MAX_SET_SIZE(MAX_N)
  ) DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .action_i      (action),
    .subset_bits_i (subset_bits),
    .index_i       (index),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .rank_o        (rank),
    .subset_out_o  (subset_out),
    .out_of_range_o(out_of_range)
  );

  always #5 clk = ~clk;

  // Exact C(a,b); zero outside the triangle
  function automatic longint unsigned choose(input int a, input int b);
    if (a < 0 || b < 0 || b > a) begin
      return 0;
    end
    return pascal[a][b];
  endfunction

  function automatic int eff_size();
    return (cur_n > MAX_N) ? MAX_N : int'(cur_n);
  endfunction

  // Expected result of one transaction under the current registers
  function automatic result_t predict_result(input logic act, input logic [DATA_W-1:0] bits,
                                             input logic [DATA_W-1:0] idx);
    int              n;
    int              kl;
    longint unsigned acc;
    longint unsigned rem;
    longint unsigned c;
    result_t         res;
    n   = eff_size();
    kl  = int'(cur_k);
    res = '0;
    acc = 0;
    if (act == ACT_RANK) begin
      // set bit consumes a chosen element, clear bit skips the subsets that set it
      for (int p = 0; p < n && kl > 0; p++) begin
        if (bits[p]) begin
          kl--;
        end else begin
          acc += choose(n - p - 1, kl - 1);
        end
      end
      res.rank = acc[DATA_W-1:0];
    end else begin
      rem = 64'(idx);
      if (rem >= choose(n, kl)) begin
        res.oor = 1'b1;
      end else begin
        for (int p = 0; p < n && kl > 0; p++) begin
          c = choose(n - p - 1, kl - 1);
          if (rem < c) begin
            res.subset[p] = 1'b1;
            kl--;
          end else begin
            rem -= c;
          end
        end
      end
    end
    return res;
  endfunction

  // Wait cycles for one transaction; alternates busy stretches with calm ones
  function automatic int draw_wait(input int side);
    if (run_left[side] == 0) begin
      run_left[side] = int'($urandom_range(8, 60));
      run_calm[side] = ($urandom_range(0, 3) == 0);
    end
    run_left[side]--;
    return run_calm[side] ? 0 : int'($urandom_range(0, WAIT_MAX));
  endfunction

  // Drain everything in flight, then write both registers
  task automatic program_regs(input logic [CNT_W-1:0] n, input logic [CNT_W-1:0] k);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SET_SIZE;
    cfg_data  <= n;
    @(negedge clk);
    cfg_index <= CFG_CHOSEN_COUNT;
    cfg_data  <= k;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_n = n;
    cur_k = k;
  endtask

  // One input transaction; the expectation is queued at the accepting edge
  task automatic drive_item(input logic act, input logic [DATA_W-1:0] bits,
                            input logic [DATA_W-1:0] idx, input bit typed,
                            input result_t typed_res);
    int gap;
    gap = draw_wait(0);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    action      <= act;
    subset_bits <= bits;
    index       <= idx;
    do @(posedge clk); while (!in_ready);
    pending_results.insert(pending_results.size(),
                           typed ? typed_res : predict_result(act, bits, idx));
  endtask

  // Output side: random stall before each transaction, check on accept
  initial begin
    int      stall;
    result_t exp_res;
    forever begin
      stall = draw_wait(1);
      if (stall > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_results.size() == 0) begin
        $error("unexpected result: rank %0h subset %0h oor %0b", rank, subset_out,
               out_of_range);
        failed = 1'b1;
      end else begin
        exp_res = pending_results.pop_front();
        if (rank !== exp_res.rank) begin
          $error("rank: expected %0d, got %0d", exp_res.rank, rank);
          failed = 1'b1;
        end
        if (subset_out !== exp_res.subset) begin
          $error("subset_out: expected %08h, got %08h", exp_res.subset, subset_out);
          failed = 1'b1;
        end
        if (out_of_range !== exp_res.oor) begin
          $error("out_of_range: expected %0b, got %0b", exp_res.oor, out_of_range);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("[combination_rank_unrank_core] ERROR");
    $finish;
  end

  // Main stimulus
  initial begin
    result_t          typed_res;
    logic [CNT_W-1:0] n_set;
    logic [CNT_W-1:0] k_set;
    int               n_eff;
    int               phase_len;
    int               pos;
    int               cnt;
    logic             act;
    logic [DATA_W-1:0] bits;
    logic [DATA_W-1:0] idx;
    longint unsigned  total;

    // Pascal triangle for the predictor
    for (int a = 0; a <= MAX_N; a++) begin
      for (int b = 0; b <= MAX_N; b++) begin
        if (b == 0) begin
          pascal[a][b] = 1;
        end else if (a == 0) begin
          pascal[a][b] = 0;
        end else begin
          pascal[a][b] = pascal[a-1][b-1] + pascal[a-1][b];
        end
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table: first rows run on the reset values of the registers
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].n != cur_n || dir_tab[i].k != cur_k) begin
        program_regs(dir_tab[i].n, dir_tab[i].k);
      end
      typed_res = '{rank: dir_tab[i].rank, subset: dir_tab[i].subset, oor: dir_tab[i].oor};
      drive_item(dir_tab[i].act, dir_tab[i].bits, dir_tab[i].idx, dir_tab[i].typed,
                 typed_res);
    end

    // Random phases, each with its own register setting
    while (rnd_items < RND_ITEMS) begin
      case ($urandom_range(0, 9))
        0: begin  // full width
          n_set = 6'd32;
          k_set = CNT_W'($urandom_range(0, 32));
        end
        1: begin  // saturating set size
          n_set = CNT_W'($urandom_range(33, 63));
          k_set = CNT_W'($urandom_range(0, 32));
        end
        2: begin  // k above n
          n_set = CNT_W'($urandom_range(0, 31));
          k_set = CNT_W'($urandom_range(int'(n_set) + 1, 63));
        end
        3: begin
          n_set = 6'd0;
          k_set = 6'd0;
        end
        default: begin
          n_set = CNT_W'($urandom_range(1, 32));
          k_set = CNT_W'($urandom_range(0, int'(n_set)));
        end
      endcase
      program_regs(n_set, k_set);
      n_eff     = eff_size();
      total     = choose(n_eff, int'(cur_k));
      phase_len = int'($urandom_range(30, 80));

      for (int j = 0; j < phase_len; j++) begin
        act  = 1'($urandom_range(0, 1));
        bits = $urandom;
        idx  = $urandom;
        if (act == ACT_RANK) begin
          // mostly proper k-subsets, sometimes with junk above n
          if ($urandom_range(0, 3) != 0 && cur_k <= n_eff) begin
            bits = '0;
            cnt  = 0;
            while (cnt < cur_k) begin
              pos = int'($urandom_range(0, n_eff - 1));
              if (!bits[pos]) begin
                bits[pos] = 1'b1;
                cnt++;
              end
            end
            if ($urandom_range(0, 3) == 0 && n_eff < MAX_N) begin
              bits |= $urandom & ~((32'h1 << n_eff) - 32'h1);
            end
          end
        end else if (total != 0) begin
          // mostly in-range indexes, plus the boundary on both sides
          case ($urandom_range(0, 9))
            0: idx = DATA_W'(total - 1);
            1: idx = (total <= 64'hFFFFFFFF) ? total[DATA_W-1:0] : $urandom;
            2: ;
            default: idx = DATA_W'($urandom % total);
          endcase
        end
        drive_item(act, bits, idx, 1'b0, '0);
        rnd_items++;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    // catch any stray result still coming down the chain
    repeat (LATENCY + 8) @(posedge clk);

    if (!failed) begin
      $display("[combination_rank_unrank_core] OK");
    end else begin
      $display("[combination_rank_unrank_core] ERROR");
    end
    $finish;
  end

endmodule
